// File: rtl/fcpu_pkg.sv
// Shared types and constants for the four-register 8-bit CPU.
// No dependencies; every other file of the block imports this package.
package fcpu_pkg;

  localparam int unsigned MEM_DEPTH = 256;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned NUM_REGS  = 4;

  // Item actions
  typedef enum logic [1:0] {
    ACT_STEP  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Opcodes (bits 7:4 of an instruction)
  localparam logic [3:0] OP_SYS   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_LOAD  = 4'd2;
  localparam logic [3:0] OP_STORE = 4'd3;
  localparam logic [3:0] OP_SKIP  = 4'd4;
  localparam logic [3:0] OP_JALR  = 4'd5;
  localparam logic [3:0] OP_ADD   = 4'd7;
  // Opcodes 12..15: shift-left-immediate family
  localparam logic [1:0] OP_SLI_HI = 2'b11;

  // rs selector that qualifies HALT and SKIPNZ
  localparam logic [1:0] RS_HALT = 2'd1;
  localparam logic [1:0] RS_SKIP = 2'd1;

  localparam logic [DATA_W-1:0] PC_RESET = 8'd1;

  // Control state, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_LOAD  = 4'b0100,
    ST_READ  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] pc;
    logic [DATA_W-1:0] instruction;
    logic [DATA_W-1:0] reg_a;
    logic [DATA_W-1:0] reg_b;
    logic [DATA_W-1:0] reg_c;
    logic [DATA_W-1:0] reg_d;
    logic              halted;
    logic [DATA_W-1:0] read_data;
  } result_t;

endpackage

// File: rtl/fcpu_if.sv
// Valid/ready channel interfaces for the CPU's item input and result output.
// Depends on fcpu_pkg.
interface fcpu_in_if import fcpu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface fcpu_out_if import fcpu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] pc;
  logic [DATA_W-1:0] instruction;
  logic [DATA_W-1:0] reg_a;
  logic [DATA_W-1:0] reg_b;
  logic [DATA_W-1:0] reg_c;
  logic [DATA_W-1:0] reg_d;
  logic              halted;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, pc, instruction, reg_a, reg_b, reg_c, reg_d, halted,
                  read_data, input ready);
  modport sink   (input valid, pc, instruction, reg_a, reg_b, reg_c, reg_d, halted,
                  read_data, output ready);
endinterface

// File: rtl/four_register_8bit_cpu.sv
// Top level of the four-register 8-bit CPU: sequencer, register file, result register.
// Depends on fcpu_pkg, fcpu_if, fcpu_mem and fcpu_in_buf.
//
// Usage:
//   in_i  - valid/ready channel; each transfer carries one item: a step
//           (execute one instruction), a memory byte write, or a memory byte read.
//   out_o - valid/ready channel; exactly one result transfer per item, in order,
//           reporting pc, registers A..D and the halt flag after the item, plus the
//           executed instruction (steps) or the read byte (reads).
// Result path (input item to result valid, unstalled):
//   write, unused action, step while halted : result registered from ST_IDLE
//   read, non-LOAD step                     : via ST_READ or ST_FETCH
//   LOAD step                               : via ST_FETCH, then ST_LOAD
// Items are sequenced one at a time, set by the single memory port (instruction fetch,
//   then the data access of a LOAD); the one-entry input buffer can take the next item.
// Reset: memory reads as zero (per-byte valid bits cleared at once), registers zero,
//   pc one, not halted; items are taken right after reset, no clearing pass.
// Stall: a result waits in the output register; up to two more items are taken: one
//   advances until its own result is due and holds, the next waits in the buffer.
module four_register_8bit_cpu import fcpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcpu_in_if.sink    in_i,
  fcpu_out_if.source out_o
);

  // Input buffer
  logic     buf_valid;
  in_item_t buf_item;
  logic     pop;

  fcpu_in_buf u_in_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (buf_valid),
    .item_o  (buf_item),
    .pop_i   (pop)
  );

  // Main memory
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  fcpu_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Architectural state
  logic [DATA_W-1:0] rf_q [NUM_REGS];
  logic [DATA_W-1:0] rf_d [NUM_REGS];
  logic [DATA_W-1:0] pc_q, pc_d;
  logic              halt_q, halt_d;
  state_e            state_q, state_d;
  logic [DATA_W-1:0] insn_q, insn_d;   // held across the LOAD data access

  // Result register
  result_t           out_q;
  logic              out_valid_q;
  logic              out_free;
  logic              emit;
  logic [DATA_W-1:0] res_insn;
  logic [DATA_W-1:0] res_rdata;

  // Decode of the fetched byte (valid in ST_FETCH)
  logic [3:0]        op;
  logic [1:0]        rd;
  logic [1:0]        rs;
  logic [DATA_W-1:0] src;
  logic [1:0]        ld_rd;

  assign op    = mem_rdata[7:4];
  assign rd    = mem_rdata[3:2];
  assign rs    = mem_rdata[1:0];
  assign src   = rf_q[rs];
  assign ld_rd = insn_q[3:2];

  // Output register frees this cycle if empty or being taken.
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d   = state_q;
    rf_d      = rf_q;
    pc_d      = pc_q;
    halt_d    = halt_q;
    insn_d    = insn_q;
    mem_req   = '0;
    pop       = 1'b0;
    emit      = 1'b0;
    res_insn  = '0;
    res_rdata = '0;

    case (state_q)
      ST_IDLE: begin
        if (buf_valid) begin
          case (buf_item.action)
            ACT_STEP: begin
              if (!halt_q) begin
                // Fetch mem[pc-1]; wraps to the last byte at pc zero.
                mem_req.en   = 1'b1;
                mem_req.addr = pc_q - 8'd1;
                pop          = 1'b1;
                state_d      = ST_FETCH;
              end else if (out_free) begin
                pop  = 1'b1;
                emit = 1'b1;
              end
            end
            ACT_WRITE: begin
              if (out_free) begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = buf_item.address;
                mem_req.wdata = buf_item.write_data;
                pop           = 1'b1;
                emit          = 1'b1;
              end
            end
            ACT_READ: begin
              mem_req.en   = 1'b1;
              mem_req.addr = buf_item.address;
              pop          = 1'b1;
              state_d      = ST_READ;
            end
            default: begin
              if (out_free) begin
                pop  = 1'b1;
                emit = 1'b1;
              end
            end
          endcase
        end
      end

      ST_FETCH: begin
        insn_d = mem_rdata;
        if (op == OP_LOAD) begin
          // Data read uses the port next; no commit until it returns.
          mem_req.en   = 1'b1;
          mem_req.addr = src;
          state_d      = ST_LOAD;
        end else if (out_free) begin
          // Read data stays put while stalled: no request is issued here.
          emit     = 1'b1;
          res_insn = mem_rdata;
          pc_d     = pc_q + 8'd1;
          state_d  = ST_IDLE;
          case (op)
            OP_SYS: begin
              if (rs == RS_HALT) halt_d = 1'b1;
            end
            OP_SUB: rf_d[rd] = rf_q[rd] - src;
            OP_STORE: begin
              mem_req.en    = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.addr  = src;
              mem_req.wdata = rf_q[rd];
            end
            OP_SKIP: begin
              if (rs == RS_SKIP && rf_q[rd] != '0) pc_d = pc_q + 8'd2;
            end
            OP_JALR: begin
              // Source read from the old file, so rd == rs still jumps right.
              pc_d     = src + 8'd1;
              rf_d[rd] = pc_q + 8'd1;
            end
            OP_ADD: rf_d[rd] = rf_q[rd] + src;
            default: begin
              // Shift-left-immediate: immediate fits in the vacated nibble.
              if (op[3:2] == OP_SLI_HI) rf_d[rd] = {rf_q[rd][3:0], op[1:0], rs};
            end
          endcase
        end
      end

      ST_LOAD: begin
        if (out_free) begin
          rf_d[ld_rd] = mem_rdata;
          pc_d        = pc_q + 8'd1;
          emit        = 1'b1;
          res_insn    = insn_q;
          state_d     = ST_IDLE;
        end
      end

      ST_READ: begin
        if (out_free) begin
          emit      = 1'b1;
          res_rdata = mem_rdata;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= PC_RESET;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      rf_q    <= rf_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    insn_q <= insn_d;
    if (emit) begin
      out_q <= '{pc: pc_d, instruction: res_insn, reg_a: rf_d[0], reg_b: rf_d[1],
                 reg_c: rf_d[2], reg_d: rf_d[3], halted: halt_d,
                 read_data: res_rdata};
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pc          = out_q.pc;
  assign out_o.instruction = out_q.instruction;
  assign out_o.reg_a       = out_q.reg_a;
  assign out_o.reg_b       = out_q.reg_b;
  assign out_o.reg_c       = out_q.reg_c;
  assign out_o.reg_d       = out_q.reg_d;
  assign out_o.halted      = out_q.halted;
  assign out_o.read_data   = out_q.read_data;

endmodule

// File: rtl/fcpu_mem.sv
// Single-port 256x8 main memory, registered read.
// Per-byte valid bits make never-written bytes read as zero after reset.
module fcpu_mem import fcpu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_req_t          req_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0]    mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid_q;
  logic [DATA_W-1:0]    rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en && req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.en && !req_i.we) begin
      rdata_q <= valid_q[req_i.addr] ? mem_q[req_i.addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.en && req_i.we) begin
      valid_q[req_i.addr] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fcpu_in_buf.sv
// One-entry input buffer: decouples input ready from the control sequencer.
// Depends on fcpu_pkg and fcpu_in_if.
module fcpu_in_buf import fcpu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fcpu_in_if.sink   in_i,
  output logic      valid_o,
  output in_item_t  item_o,
  input  logic      pop_i
);

  logic     valid_q;
  in_item_t item_q;

  assign in_i.ready = !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= '{action: in_i.action, address: in_i.address,
                  write_data: in_i.write_data};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
